// ===== rtl/core/bank_switch_irq_mapper_macros.svh =====
// Assertion macros shared by the mapper RTL.
`ifndef BANK_SWITCH_IRQ_MAPPER_MACROS_SVH
`define BANK_SWITCH_IRQ_MAPPER_MACROS_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define BSIM_ASSERT_NOW(label, clk, rst_n, cond, impl) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (impl)) \
        else $error("bank switch irq mapper assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define BSIM_ASSERT_NEXT(label, clk, rst_n, cond, impl) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (impl)) \
        else $error("bank switch irq mapper assertion failed");
`else
`define BSIM_ASSERT_NOW(label, clk, rst_n, cond, impl)
`define BSIM_ASSERT_NEXT(label, clk, rst_n, cond, impl)
`endif
`endif

// ===== rtl/core/bsim_pkg.sv =====
package bsim_pkg;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] address;
        logic [7:0]  data;
        logic [3:0]  slot;
    } req_t;

    typedef struct packed {
        logic [1:0] target;
        logic [7:0] bank;
        logic       irq_request;
        logic       vertical_mirror;
    } rsp_t;

    // Commands.
    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_TICK   = 2'd1;
    localparam logic [1:0] CMD_PPU    = 2'd2;
    localparam logic [1:0] CMD_PRG    = 2'd3;

    // Result targets.
    localparam logic [1:0] TGT_NONE   = 2'd0;
    localparam logic [1:0] TGT_PRG    = 2'd1;
    localparam logic [1:0] TGT_CHR    = 2'd2;
    localparam logic [1:0] TGT_CIRAM  = 2'd3;

    // Write page codes, address bits 15..11.
    localparam logic [4:0] PAGE_IRQ_LO = 5'h0A;
    localparam logic [4:0] PAGE_IRQ_HI = 5'h0B;
    localparam logic [4:0] PAGE_CHR_LO = 5'h10;
    localparam logic [4:0] PAGE_CHR_HI = 5'h17;
    localparam logic [4:0] PAGE_NT_LO  = 5'h18;
    localparam logic [4:0] PAGE_NT_HI  = 5'h1B;
    localparam logic [4:0] PAGE_PRG_LO = 5'h1C;
    localparam logic [4:0] PAGE_PRG_HI = 5'h1E;

    localparam logic [15:0] LINE_CYCLES  = 16'd113;
    localparam logic [7:0]  BANK_RESET   = 8'hFF;
    localparam logic [7:0]  RAM_BANK_MIN = 8'hE0;
    localparam logic [7:0]  PRG_LAST     = 8'h3F;
    localparam logic [7:0]  PRG_MASK     = 8'h3F;
    localparam logic [7:0]  CIRAM_MASK   = 8'h1F;
    localparam logic [3:0]  PRG_SLOTS    = 4'd3;

endpackage

// ===== rtl/core/bank_switch_irq_mapper.sv =====
// Bank-switching and scanline IRQ mapper.
// Input channel req (req_valid, req_stall) carries one item: a CPU register
// write, a scanline tick, a PPU 1 KB slot lookup or a CPU 8 KB slot lookup.
// Output channel rsp (rsp_valid, rsp_stall) returns exactly one result item
// per input item, in order: target and bank for lookups, irq_request for
// ticks, and the vertical mirroring bit in every result.
// The result of an item accepted at a clock edge is registered at that edge and is
// valid after it. Throughput is one item per cycle while the receiver does not stall;
// the whole decode, the counter add with saturation and the bank lookup sit between
// the input handshake and the result register.
// When the receiver stalls, the result register holds its item and
// req_stall rises, so no new item is taken until the held result leaves.
// Reset sets all bank registers to 0xFF, clears the IRQ counter and its
// enable, and empties the result register.
`include "bank_switch_irq_mapper_macros.svh"

module bank_switch_irq_mapper (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  bsim_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output bsim_pkg::rsp_t  rsp
);

    logic [7:0]  chr_bank_reg [8];
    logic [7:0]  chr_bank_next [8];
    logic [7:0]  nt_bank_reg [4];
    logic [7:0]  nt_bank_next [4];
    logic [7:0]  prg_bank_reg [3];
    logic [7:0]  prg_bank_next [3];
    logic        irq_enable_reg;
    logic        irq_enable_next;
    logic [15:0] irq_count_reg;
    logic [15:0] irq_count_next;
    logic        rsp_valid_reg;
    bsim_pkg::rsp_t rsp_reg;
    bsim_pkg::rsp_t rsp_next;

    logic        accept;
    logic [4:0]  page;
    logic [16:0] tick_sum;
    logic        irq_hit;

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign page     = req.address[15:11];
    assign tick_sum = {1'b0, irq_count_reg} + {1'b0, bsim_pkg::LINE_CYCLES};

    // Register writes and counter ticks.
    always_comb
    begin
        chr_bank_next   = chr_bank_reg;
        nt_bank_next    = nt_bank_reg;
        prg_bank_next   = prg_bank_reg;
        irq_enable_next = irq_enable_reg;
        irq_count_next  = irq_count_reg;
        irq_hit         = 1'b0;
        if (accept && req.command == bsim_pkg::CMD_WRITE) begin
            priority if (page == bsim_pkg::PAGE_IRQ_LO) begin
                irq_count_next[7:0] = req.data;
            end else if (page == bsim_pkg::PAGE_IRQ_HI) begin
                irq_count_next[15:8] = {1'b0, req.data[6:0]};
                irq_enable_next      = req.data[7];
            end else if (page >= bsim_pkg::PAGE_CHR_LO && page <= bsim_pkg::PAGE_CHR_HI) begin
                chr_bank_next[page[2:0]] = req.data;
            end else if (page >= bsim_pkg::PAGE_NT_LO && page <= bsim_pkg::PAGE_NT_HI) begin
                nt_bank_next[page[1:0]] = req.data;
            end else if (page >= bsim_pkg::PAGE_PRG_LO && page <= bsim_pkg::PAGE_PRG_HI) begin
                prg_bank_next[page[1:0]] = req.data;
            end else begin
                irq_count_next = irq_count_reg;
            end
        end else if (accept && req.command == bsim_pkg::CMD_TICK && irq_enable_reg) begin
            // The counter sticks at all ones instead of wrapping.
            irq_count_next = tick_sum[16] ? 16'hFFFF : tick_sum[15:0];
            irq_hit        = irq_count_next[15];
        end
    end

    // Result of the item, built from the state as the item leaves it.
    always_comb
    begin
        logic [7:0] chr_b;
        logic [7:0] nt_b;
        logic       keep_rom;
        chr_b    = chr_bank_reg[req.slot[2:0]];
        nt_b     = nt_bank_reg[req.slot[1:0]];
        keep_rom = req.slot[2] ? prg_bank_reg[1][7] : prg_bank_reg[1][6];

        rsp_next.target          = bsim_pkg::TGT_NONE;
        rsp_next.bank            = 8'd0;
        rsp_next.irq_request     = 1'b0;
        rsp_next.vertical_mirror = prg_bank_next[0][6];
        unique case (req.command)
            bsim_pkg::CMD_WRITE: begin
                rsp_next.target = bsim_pkg::TGT_NONE;
            end
            bsim_pkg::CMD_TICK: begin
                rsp_next.irq_request = irq_hit;
            end
            bsim_pkg::CMD_PPU: begin
                if (!req.slot[3]) begin
                    if (chr_b < bsim_pkg::RAM_BANK_MIN || keep_rom) begin
                        rsp_next.target = bsim_pkg::TGT_CHR;
                        rsp_next.bank   = chr_b;
                    end else begin
                        rsp_next.target = bsim_pkg::TGT_CIRAM;
                        rsp_next.bank   = chr_b & bsim_pkg::CIRAM_MASK;
                    end
                end else begin
                    if (nt_b < bsim_pkg::RAM_BANK_MIN) begin
                        rsp_next.target = bsim_pkg::TGT_CHR;
                        rsp_next.bank   = nt_b;
                    end else begin
                        rsp_next.target = bsim_pkg::TGT_CIRAM;
                        rsp_next.bank   = {7'd0, nt_b[0]};
                    end
                end
            end
            bsim_pkg::CMD_PRG: begin
                if (req.slot < bsim_pkg::PRG_SLOTS) begin
                    rsp_next.target = bsim_pkg::TGT_PRG;
                    rsp_next.bank   = prg_bank_reg[req.slot[1:0]] & bsim_pkg::PRG_MASK;
                end else if (req.slot == bsim_pkg::PRG_SLOTS) begin
                    rsp_next.target = bsim_pkg::TGT_PRG;
                    rsp_next.bank   = bsim_pkg::PRG_LAST;
                end
            end
            default: begin
                rsp_next.target = bsim_pkg::TGT_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < 8; i++) begin
                chr_bank_reg[i] <= bsim_pkg::BANK_RESET;
            end
            for (int i = 0; i < 4; i++) begin
                nt_bank_reg[i] <= bsim_pkg::BANK_RESET;
            end
            for (int i = 0; i < 3; i++) begin
                prg_bank_reg[i] <= bsim_pkg::BANK_RESET;
            end
            irq_enable_reg <= 1'b0;
            irq_count_reg  <= 16'd0;
            rsp_valid_reg  <= 1'b0;
        end else begin
            chr_bank_reg   <= chr_bank_next;
            nt_bank_reg    <= nt_bank_next;
            prg_bank_reg   <= prg_bank_next;
            irq_enable_reg <= irq_enable_next;
            irq_count_reg  <= irq_count_next;
            if (accept) begin
                rsp_valid_reg <= 1'b1;
            end else if (!rsp_stall) begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            rsp_reg <= rsp_next;
        end
    end

    `BSIM_ASSERT_NOW(a_irq_needs_count, clk, rst_n, rsp_valid_reg && rsp_reg.irq_request, irq_count_reg[15] && irq_enable_reg)
    `BSIM_ASSERT_NOW(a_irq_only_on_tick, clk, rst_n, rsp_valid_reg && rsp_reg.irq_request, rsp_reg.target == bsim_pkg::TGT_NONE)
    `BSIM_ASSERT_NOW(a_mirror_tracks_reg, clk, rst_n, rsp_valid_reg, rsp_reg.vertical_mirror == prg_bank_reg[0][6])
    `BSIM_ASSERT_NEXT(a_tick_no_decrease, clk, rst_n, accept && req.command == bsim_pkg::CMD_TICK, irq_count_reg >= $past(irq_count_reg))

endmodule

// ===== tb/sv/tb.sv =====
module tb;
    import bsim_pkg::*;

    localparam int DIRECTED_LEN = 25;
    localparam int ITEMS_PER_PHASE = 500;
    localparam int LONG_HOLD_CYCLES = 80;

    typedef struct packed {
        req_t item;
        logic known;
        rsp_t answer;
    } directed_step_t;

    // Rows with known = 1 carry an answer that can be read straight off the reset
    // state or the decode rules; the rest are predicted.
    localparam directed_step_t DIRECTED_STEPS [DIRECTED_LEN] = '{
        '{'{CMD_PPU,   16'h0000, 8'h00, 4'd0},  1'b1, '{TGT_CHR,   8'hFF, 1'b0, 1'b1}},
        '{'{CMD_PPU,   16'h0000, 8'h00, 4'd15}, 1'b1, '{TGT_CIRAM, 8'h01, 1'b0, 1'b1}},
        '{'{CMD_PRG,   16'h0000, 8'h00, 4'd0},  1'b1, '{TGT_PRG,   8'h3F, 1'b0, 1'b1}},
        '{'{CMD_PRG,   16'h0000, 8'h00, 4'd3},  1'b1, '{TGT_PRG,   8'h3F, 1'b0, 1'b1}},
        '{'{CMD_PRG,   16'h0000, 8'h00, 4'd15}, 1'b1, '{TGT_NONE,  8'h00, 1'b0, 1'b1}},
        '{'{CMD_TICK,  16'h0000, 8'h00, 4'd0},  1'b1, '{TGT_NONE,  8'h00, 1'b0, 1'b1}},
        '{'{CMD_WRITE, 16'hE800, 8'h00, 4'd0},  1'b1, '{TGT_NONE,  8'h00, 1'b0, 1'b1}},
        '{'{CMD_PPU,   16'h0000, 8'h00, 4'd3},  1'b1, '{TGT_CIRAM, 8'h1F, 1'b0, 1'b1}},
        '{'{CMD_WRITE, 16'hE000, 8'h00, 4'd0},  1'b1, '{TGT_NONE,  8'h00, 1'b0, 1'b0}},
        '{'{CMD_WRITE, 16'h8000, 8'hDF, 4'd0},  1'b0, '0},
        '{'{CMD_PPU,   16'h0000, 8'h00, 4'd0},  1'b0, '0},
        '{'{CMD_WRITE, 16'hBFFF, 8'hE5, 4'd0},  1'b0, '0},
        '{'{CMD_PPU,   16'h0000, 8'h00, 4'd7},  1'b0, '0},
        '{'{CMD_WRITE, 16'hEFFF, 8'h80, 4'd0},  1'b0, '0},
        '{'{CMD_PPU,   16'h0000, 8'h00, 4'd7},  1'b0, '0},
        '{'{CMD_WRITE, 16'hD800, 8'h00, 4'd0},  1'b0, '0},
        '{'{CMD_PPU,   16'h0000, 8'h00, 4'd11}, 1'b0, '0},
        '{'{CMD_WRITE, 16'hFFFF, 8'h00, 4'd15}, 1'b1, '{TGT_NONE,  8'h00, 1'b0, 1'b0}},
        '{'{CMD_WRITE, 16'h0000, 8'hFF, 4'd0},  1'b1, '{TGT_NONE,  8'h00, 1'b0, 1'b0}},
        '{'{CMD_WRITE, 16'h5000, 8'hF0, 4'd0},  1'b0, '0},
        '{'{CMD_WRITE, 16'h5FFF, 8'hFF, 4'd0},  1'b0, '0},
        '{'{CMD_TICK,  16'hFFFF, 8'hFF, 4'd15}, 1'b0, '0},
        '{'{CMD_WRITE, 16'h5800, 8'h7F, 4'd0},  1'b0, '0},
        '{'{CMD_TICK,  16'h0000, 8'h00, 4'd0},  1'b0, '0},
        '{'{CMD_PRG,   16'h0000, 8'h00, 4'd2},  1'b0, '0}
    };

    logic clk;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    // Mirror of the cartridge registers.
    logic [7:0]  chr_bank [8];
    logic [7:0]  nt_bank [4];
    logic [7:0]  prg_bank [3];
    logic        irq_on;
    logic [15:0] irq_cnt;

    rsp_t answers_due [$];
    int   fail_count = 0;
    int   items_sent = 0;
    int   send_idle_pct = 27;
    int   rcv_stall_pct = 60;
    bit   long_hold_due = 1'b0;

    bank_switch_irq_mapper DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("** bank_switch_irq_mapper: FAILED **");
        $finish;
    end

    // Applies one access to the register mirror and returns the answer it gives.
    function automatic rsp_t resolve_access(input req_t r);
        rsp_t        o;
        logic [4:0]  page;
        logic [7:0]  b;
        logic [16:0] sum;
        logic        keep;
        o = '0;
        page = r.address[15:11];
        case (r.command)
            CMD_WRITE:
            begin
                if (page == PAGE_IRQ_LO)
                    irq_cnt[7:0] = r.data;
                else if (page == PAGE_IRQ_HI)
                begin
                    irq_cnt[15:8] = {1'b0, r.data[6:0]};
                    irq_on = r.data[7];
                end
                else if (page >= PAGE_CHR_LO && page <= PAGE_CHR_HI)
                    chr_bank[page[2:0]] = r.data;
                else if (page >= PAGE_NT_LO && page <= PAGE_NT_HI)
                    nt_bank[page[1:0]] = r.data;
                else if (page >= PAGE_PRG_LO && page <= PAGE_PRG_HI)
                    prg_bank[page[1:0]] = r.data;
            end
            CMD_TICK:
            begin
                if (irq_on)
                begin
                    sum = {1'b0, irq_cnt} + {1'b0, LINE_CYCLES};
                    irq_cnt = sum[16] ? 16'hFFFF : sum[15:0];
                    o.irq_request = irq_cnt[15];
                end
            end
            CMD_PPU:
            begin
                if (r.slot < 4'd8)
                begin
                    b = chr_bank[r.slot[2:0]];
                    // Slots 0-3 are kept in ROM by bit 6, slots 4-7 by bit 7.
                    keep = r.slot[2] ? prg_bank[1][7] : prg_bank[1][6];
                    if (b < RAM_BANK_MIN || keep)
                    begin
                        o.target = TGT_CHR;
                        o.bank = b;
                    end
                    else
                    begin
                        o.target = TGT_CIRAM;
                        o.bank = b & CIRAM_MASK;
                    end
                end
                else
                begin
                    b = nt_bank[r.slot[1:0]];
                    if (b < RAM_BANK_MIN)
                    begin
                        o.target = TGT_CHR;
                        o.bank = b;
                    end
                    else
                    begin
                        o.target = TGT_CIRAM;
                        o.bank = {7'd0, b[0]};
                    end
                end
            end
            default:
            begin
                if (r.slot < PRG_SLOTS)
                begin
                    o.target = TGT_PRG;
                    o.bank = prg_bank[r.slot[1:0]] & PRG_MASK;
                end
                else if (r.slot == PRG_SLOTS)
                begin
                    o.target = TGT_PRG;
                    o.bank = PRG_LAST;
                end
            end
        endcase
        o.vertical_mirror = prg_bank[0][6];
        return o;
    endfunction

    function automatic req_t random_access();
        req_t r;
        int   pick;
        r.command = 2'($urandom_range(3));
        r.address = 16'($urandom);
        r.data = 8'($urandom);
        r.slot = 4'($urandom);
        pick = $urandom_range(15);
        // Most writes land on a decoded page; the rest fall anywhere.
        if (r.command == CMD_WRITE && pick < 12)
            r.address[15:11] = (pick == 0) ? PAGE_IRQ_LO : PAGE_CHR_LO + 5'($urandom_range(14));
        if (r.command == CMD_WRITE && $urandom_range(1) == 1)
            r.data[7:5] = 3'b111;
        if (r.command == CMD_PRG && pick < 10)
            r.slot = 4'($urandom_range(3));
        return r;
    endfunction

    // Offers one item, waits for it to be taken, then records its answer.
    task automatic send_item(input req_t r, input logic known, input rsp_t answer);
        rsp_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (req_stall);
        predicted = resolve_access(r);
        answers_due.push_back(known ? answer : predicted);
        items_sent++;
    endtask

    // Loads the counter and then mostly ticks it; a saturating run starts near
    // the top of the enabled range and runs long enough to reach the ceiling.
    task automatic irq_run(input bit saturate);
        int   ticks;
        req_t r;
        ticks = saturate ? 400 + $urandom_range(40) : $urandom_range(1, 40);
        r = '0;
        r.command = CMD_WRITE;
        r.address = {PAGE_IRQ_LO, 11'($urandom)};
        r.data = 8'($urandom);
        send_item(r, 1'b0, '0);
        r.address = {PAGE_IRQ_HI, 11'($urandom)};
        r.data = saturate ? 8'hFF : {($urandom_range(7) != 0), 7'($urandom)};
        send_item(r, 1'b0, '0);
        repeat (ticks)
        begin
            r = random_access();
            if ($urandom_range(7) != 0)
                r.command = CMD_TICK;
            else if (saturate && r.command == CMD_WRITE)
                r.command = CMD_PPU;
            send_item(r, 1'b0, '0);
        end
    endtask

    initial
    begin : rsp_pacing
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && long_hold_due)
            begin
                hold_left = LONG_HOLD_CYCLES;
                long_hold_due = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= ($urandom_range(99) < rcv_stall_pct);
        end
    end

    always @(posedge clk)
    begin : answer_check
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (answers_due.size() == 0)
            begin
                $error("unexpected result item: target %0d bank %0h", rsp.target, rsp.bank);
                fail_count++;
            end
            else
            begin
                want = answers_due.pop_front();
                if (rsp.target !== want.target)
                begin
                    $error("target: expected %0d, got %0d", want.target, rsp.target);
                    fail_count++;
                end
                if (rsp.bank !== want.bank)
                begin
                    $error("bank: expected %0h, got %0h", want.bank, rsp.bank);
                    fail_count++;
                end
                if (rsp.irq_request !== want.irq_request)
                begin
                    $error("irq_request: expected %0b, got %0b",
                           want.irq_request, rsp.irq_request);
                    fail_count++;
                end
                if (rsp.vertical_mirror !== want.vertical_mirror)
                begin
                    $error("vertical_mirror: expected %0b, got %0b",
                           want.vertical_mirror, rsp.vertical_mirror);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin : stimulus
        int irq_runs;
        irq_runs = 0;
        foreach (chr_bank[i])
            chr_bank[i] = BANK_RESET;
        foreach (nt_bank[i])
            nt_bank[i] = BANK_RESET;
        foreach (prg_bank[i])
            prg_bank[i] = BANK_RESET;
        irq_on = 1'b0;
        irq_cnt = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_LEN; i++)
            send_item(DIRECTED_STEPS[i].item, DIRECTED_STEPS[i].known,
                      DIRECTED_STEPS[i].answer);

        for (int ph = 0; ph <= 3; ph++)
        begin
            // Between phases the sender goes quiet until every answer is back.
            if (ph != 0)
            begin
                req_valid <= 1'b0;
                while (answers_due.size() != 0)
                    @(posedge clk);
            end
            if (ph == 3)
                break;
            case (ph)
                0:
                begin
                    send_idle_pct = 27;
                    rcv_stall_pct = 60;
                end
                1:
                begin
                    send_idle_pct = 60;
                    rcv_stall_pct = 27;
                end
                default:
                begin
                    send_idle_pct = 0;
                    rcv_stall_pct = 0;
                    long_hold_due = 1'b1;
                end
            endcase
            while (items_sent < DIRECTED_LEN + (ph + 1) * ITEMS_PER_PHASE)
            begin
                if ($urandom_range(9) == 0)
                begin
                    irq_run(irq_runs % 6 == 0);
                    irq_runs++;
                end
                else
                    send_item(random_access(), 1'b0, '0);
            end
        end

        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("** bank_switch_irq_mapper: PASSED **");
        else
            $display("** bank_switch_irq_mapper: FAILED **");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/bsim_pkg.sv
rtl/core/bank_switch_irq_mapper.sv
tb/sv/tb.sv
